[rtl/core/hrp_pkg.sv]
`timescale 1ns / 1ps

package hrp_pkg;

	// a line is cut once this many characters have been kept
	localparam int LINE_LIMIT = 1023;
	localparam int KEPT_W = $clog2(LINE_LIMIT + 1);

	// only "exactly two bytes" matters for the blank line, so saturate early
	localparam int CONS_W = 2;
	localparam logic [CONS_W-1:0] CONS_MAX = '1;

	localparam int ACC_W = 16;
	localparam logic [ACC_W-1:0] ACC_CAP = 16'h8000;
	localparam logic [ACC_W-1:0] CODE_POS_MAX = 16'h7fff;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;

	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_NAME      = 3'd1,
		KIND_VALUE     = 3'd2,
		KIND_HDR_END   = 3'd3,
		KIND_PAYLOAD   = 3'd4,
		KIND_STATUS_OK = 3'd5,
		KIND_MALFORMED = 3'd6,
		KIND_HDR_DONE  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		PH_STATUS  = 2'd0,
		PH_HEADERS = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_IGNORE  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		FP_NAME  = 2'd0,
		FP_SKIP  = 2'd1,
		FP_VALUE = 2'd2
	} field_part_t;

	typedef enum logic [3:0] {
		SM_H           = 4'd0,
		SM_T1          = 4'd1,
		SM_T2          = 4'd2,
		SM_P           = 4'd3,
		SM_SLASH       = 4'd4,
		SM_SKIP_TOK_WS = 4'd5,
		SM_TOKEN       = 4'd6,
		SM_SKIP_NUM_WS = 4'd7,
		SM_SIGN        = 4'd8,
		SM_DIGITS      = 4'd9,
		SM_DONE        = 4'd10,
		SM_FAIL        = 4'd11
	} status_match_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] status_code;
	} result_t;

endpackage

[rtl/core/hrp_status_scan.sv]
`timescale 1ns / 1ps

module hrp_status_scan (
	input  logic [7:0]                 c,
	input  hrp_pkg::status_match_t     match,
	input  logic [hrp_pkg::ACC_W-1:0]  accum,
	input  logic                       neg,
	output hrp_pkg::status_match_t     match_n,
	output logic [hrp_pkg::ACC_W-1:0]  accum_n,
	output logic                       neg_n
);
	import hrp_pkg::*;

	logic             is_ws;
	logic             is_dig;
	logic [3:0]       digit;
	logic [ACC_W+3:0] times_ten;
	logic [ACC_W-1:0] added;

	assign is_ws  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
	assign digit  = c[3:0];

	// accum * 10 + digit as shift-add, capped
	assign times_ten = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + {{ACC_W{1'b0}}, digit};
	assign added = (times_ten > {4'b0, ACC_CAP}) ? ACC_CAP : times_ten[ACC_W-1:0];

	always_comb begin
		match_n = match;
		accum_n = accum;
		neg_n   = neg;
		if (c == CH_NUL) begin
			// a nul ends the examined text
			match_n = ((match == SM_DIGITS) || (match == SM_DONE)) ? SM_DONE : SM_FAIL;
		end else begin
			unique case (match)
				SM_H:     match_n = (c == CH_H) ? SM_T1 : SM_FAIL;
				SM_T1:    match_n = (c == CH_T) ? SM_T2 : SM_FAIL;
				SM_T2:    match_n = (c == CH_T) ? SM_P : SM_FAIL;
				SM_P:     match_n = (c == CH_P) ? SM_SLASH : SM_FAIL;
				SM_SLASH: match_n = (c == CH_SLASH) ? SM_SKIP_TOK_WS : SM_FAIL;
				SM_SKIP_TOK_WS: begin
					if (!is_ws) match_n = SM_TOKEN;
				end
				SM_TOKEN: begin
					if (is_ws) match_n = SM_SKIP_NUM_WS;
				end
				SM_SKIP_NUM_WS: begin
					if (is_ws) begin
						match_n = match;
					end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
						neg_n   = (c == CH_MINUS);
						match_n = SM_SIGN;
					end else if (is_dig) begin
						accum_n = {{(ACC_W-4){1'b0}}, digit};
						match_n = SM_DIGITS;
					end else begin
						match_n = SM_FAIL;
					end
				end
				SM_SIGN: begin
					if (is_dig) begin
						accum_n = {{(ACC_W-4){1'b0}}, digit};
						match_n = SM_DIGITS;
					end else begin
						match_n = SM_FAIL;
					end
				end
				SM_DIGITS: begin
					if (is_dig) accum_n = added;
					else match_n = SM_DONE;
				end
				SM_DONE: match_n = SM_DONE;
				default: match_n = SM_FAIL;
			endcase
		end
	end

endmodule

[rtl/core/hrp_parse_state.sv]
`timescale 1ns / 1ps

module hrp_parse_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       c,
	input  logic             fin,
	output hrp_pkg::result_t res
);
	import hrp_pkg::*;

	phase_t              phase_q, phase_n;
	logic                prev_cr_q, prev_cr_n;
	logic [CONS_W-1:0]   cons_q, cons_n;
	logic [KEPT_W-1:0]   kept_q, kept_n;
	field_part_t         fpart_q, fpart_n;
	status_match_t       match_q, match_n, scan_match;
	logic [ACC_W-1:0]    accum_q, accum_n, scan_accum;
	logic                neg_q, neg_n, scan_neg;

	logic [KEPT_W-1:0]   kept_inc;
	logic [CONS_W-1:0]   cons_inc;
	logic                is_crlf;
	logic                ended;

	hrp_status_scan u_scan (
		.c       (c),
		.match   (match_q),
		.accum   (accum_q),
		.neg     (neg_q),
		.match_n (scan_match),
		.accum_n (scan_accum),
		.neg_n   (scan_neg)
	);

	assign kept_inc = kept_q + 1'b1;
	assign cons_inc = (cons_q == CONS_MAX) ? cons_q : cons_q + 1'b1;
	assign is_crlf  = (c == CH_LF) && prev_cr_q;

	always_comb begin
		phase_n   = phase_q;
		prev_cr_n = prev_cr_q;
		cons_n    = cons_q;
		kept_n    = kept_q;
		fpart_n   = fpart_q;
		match_n   = match_q;
		accum_n   = accum_q;
		neg_n     = neg_q;
		ended     = 1'b0;
		res       = '{kind: KIND_NONE, out_byte: 8'h00, status_code: 16'h0000};

		unique case (phase_q)
			PH_STATUS: begin
				cons_n = cons_inc;
				if (is_crlf) begin
					ended = 1'b1;
				end else begin
					if (c != CH_CR) begin
						match_n = scan_match;
						accum_n = scan_accum;
						neg_n   = scan_neg;
						kept_n  = kept_inc;
						ended   = (kept_inc >= KEPT_W'(LINE_LIMIT));
					end
					prev_cr_n = (c == CH_CR);
				end
				if (ended || fin) begin
					if ((match_n == SM_DIGITS) || (match_n == SM_DONE)) begin
						res.kind = KIND_STATUS_OK;
						if (neg_n) res.status_code = ~accum_n + 1'b1;
						else if (accum_n > CODE_POS_MAX) res.status_code = CODE_POS_MAX;
						else res.status_code = accum_n;
						phase_n = PH_HEADERS;
					end else begin
						res.kind = KIND_MALFORMED;
						phase_n  = PH_IGNORE;
					end
					prev_cr_n = 1'b0;
					cons_n    = '0;
					kept_n    = '0;
					fpart_n   = FP_NAME;
				end
			end
			PH_HEADERS: begin
				cons_n = cons_inc;
				if (is_crlf) begin
					// blank line is exactly cr lf
					if (cons_inc == CONS_W'(2)) begin
						res.kind = KIND_HDR_DONE;
						phase_n  = PH_PAYLOAD;
					end else begin
						res.kind = KIND_HDR_END;
					end
					prev_cr_n = 1'b0;
					cons_n    = '0;
					kept_n    = '0;
					fpart_n   = FP_NAME;
				end else if (c != CH_CR) begin
					unique case (fpart_q)
						FP_NAME: begin
							if (c == CH_COLON) begin
								fpart_n = FP_SKIP;
							end else begin
								res.kind     = KIND_NAME;
								res.out_byte = c;
							end
						end
						FP_SKIP: fpart_n = FP_VALUE;
						default: begin
							res.kind     = KIND_VALUE;
							res.out_byte = c;
						end
					endcase
					prev_cr_n = 1'b0;
					kept_n    = kept_inc;
					if (kept_inc >= KEPT_W'(LINE_LIMIT)) begin
						// line cut at the limit, a name or value byte stays in out_byte
						res.kind  = KIND_HDR_END;
						cons_n    = '0;
						kept_n    = '0;
						fpart_n   = FP_NAME;
					end
				end else begin
					prev_cr_n = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res.kind     = KIND_PAYLOAD;
				res.out_byte = c;
			end
			default: begin
				res.kind = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STATUS;
			prev_cr_q <= 1'b0;
			cons_q    <= '0;
			kept_q    <= '0;
			fpart_q   <= FP_NAME;
			match_q   <= SM_H;
			accum_q   <= '0;
			neg_q     <= 1'b0;
		end else if (step_en) begin
			if (fin) begin
				// end of response: back to a fresh start
				phase_q   <= PH_STATUS;
				prev_cr_q <= 1'b0;
				cons_q    <= '0;
				kept_q    <= '0;
				fpart_q   <= FP_NAME;
				match_q   <= SM_H;
				accum_q   <= '0;
				neg_q     <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				prev_cr_q <= prev_cr_n;
				cons_q    <= cons_n;
				kept_q    <= kept_n;
				fpart_q   <= fpart_n;
				match_q   <= match_n;
				accum_q   <= accum_n;
				neg_q     <= neg_n;
			end
		end
	end

	a_kept_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q < KEPT_W'(LINE_LIMIT))
		else $error("kept count reached line limit without ending the line");

	a_accum_capped: assert property (@(posedge clk) disable iff (!arst_n)
		accum_q <= ACC_CAP)
		else $error("status code accumulator above cap");

	a_fin_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && fin |=> (phase_q == PH_STATUS) && (kept_q == '0) && (match_q == SM_H))
		else $error("state not restarted after final byte");

	a_field_part_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(fpart_q == FP_NAME) || (fpart_q == FP_SKIP) || (fpart_q == FP_VALUE))
		else $error("field part holds an unused code");

endmodule

[rtl/core/http_response_header_parser.sv]
// HTTP response header parser. Raw response bytes enter on s_axis, one per beat, with tlast
// on the final byte of a response; every input beat yields exactly one result beat on
// m_axis whose tuser gives the kind (none, name byte, value byte, header line end, payload,
// status ok, malformed, headers done) and whose tlast repeats the input tlast. The parser
// sustains one byte per clock when m_axis_tready does not stall it: a byte sits in the input
// register, then the per-byte state update (status line matcher, line and field tracking)
// runs combinationally into the result register. After a final byte all parse state returns
// to reset and the next byte starts a new response.
`timescale 1ns / 1ps

module http_response_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] status_code
	output logic [2:0]  m_axis_tuser,   // [2:0] kind
	output logic        m_axis_tlast
);
	import hrp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic        valid_s2;
	result_t     res_s2;
	logic        last_s2;

	logic        out_free;
	logic        step_en;
	result_t     res;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign step_en       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	hrp_parse_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.c       (byte_s1),
		.fin     (last_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2  <= res;
			last_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.status_code, res_s2.out_byte};
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tlast  = last_s2;

	a_code_only_with_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.kind != KIND_STATUS_OK) |-> (res_s2.status_code == 16'h0000))
		else $error("status code set on a non status beat");

	a_byte_only_with_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ((res_s2.kind == KIND_NONE) || (res_s2.kind == KIND_STATUS_OK) ||
		(res_s2.kind == KIND_MALFORMED) || (res_s2.kind == KIND_HDR_DONE))
		|-> (res_s2.out_byte == 8'h00))
		else $error("out byte set on a beat that carries no byte");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> valid_s2)
		else $error("processed byte produced no result");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import hrp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} raw_beat_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ob;
		logic [15:0] code;
		logic        fin;
	} parsed_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // [7:0] out_byte, [23:8] status_code
	logic [2:0]  m_axis_tuser;           // [2:0] kind
	logic        m_axis_tlast;

	raw_beat_t    pending_bytes[$];
	parsed_beat_t expected_beats[$];
	logic [7:0]   frame_q[$];
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           mismatch_cnt = 0;

	// parser state mirror
	phase_t                ph_state;
	logic                  cr_seen;
	logic [10:0]           cons_cnt;
	logic [KEPT_W-1:0]     kept_cnt;
	field_part_t           fpart;
	status_match_t         smatch;
	logic [15:0]           acc;
	logic                  neg;

	http_response_header_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void start_line();
		cr_seen = 1'b0;
		cons_cnt = '0;
		kept_cnt = '0;
		fpart = FP_NAME;
	endfunction

	function automatic void clear_parse();
		ph_state = PH_STATUS;
		start_line();
		smatch = SM_H;
		acc = '0;
		neg = 1'b0;
	endfunction

	function automatic void push_digit(logic [7:0] c);
		logic [19:0] v;
		v = acc * 20'd10 + c - CH_ZERO;
		acc = (v > ACC_CAP) ? ACC_CAP : v[15:0];
	endfunction

	function automatic void match_status(logic [7:0] c);
		logic ws;
		logic dig;
		ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		if (c == CH_NUL) begin
			smatch = (smatch == SM_DIGITS || smatch == SM_DONE) ? SM_DONE : SM_FAIL;
		end else begin
			case (smatch)
				SM_H:     smatch = (c == CH_H) ? SM_T1 : SM_FAIL;
				SM_T1:    smatch = (c == CH_T) ? SM_T2 : SM_FAIL;
				SM_T2:    smatch = (c == CH_T) ? SM_P : SM_FAIL;
				SM_P:     smatch = (c == CH_P) ? SM_SLASH : SM_FAIL;
				SM_SLASH: smatch = (c == CH_SLASH) ? SM_SKIP_TOK_WS : SM_FAIL;
				SM_SKIP_TOK_WS: begin
					if (!ws)
						smatch = SM_TOKEN;
				end
				SM_TOKEN: begin
					if (ws)
						smatch = SM_SKIP_NUM_WS;
				end
				SM_SKIP_NUM_WS: begin
					if (ws) begin
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						neg = (c == CH_MINUS);
						smatch = SM_SIGN;
					end else if (dig) begin
						acc = '0;
						push_digit(c);
						smatch = SM_DIGITS;
					end else begin
						smatch = SM_FAIL;
					end
				end
				SM_SIGN: begin
					if (dig) begin
						acc = '0;
						push_digit(c);
						smatch = SM_DIGITS;
					end else begin
						smatch = SM_FAIL;
					end
				end
				SM_DIGITS: begin
					if (dig)
						push_digit(c);
					else
						smatch = SM_DONE;
				end
				SM_DONE: begin
				end
				default: smatch = SM_FAIL;
			endcase
		end
	endfunction

	function automatic parsed_beat_t parse_byte(logic [7:0] c, logic fin);
		parsed_beat_t r;
		logic line_end;
		r.kind = KIND_NONE;
		r.ob = 8'h00;
		r.code = 16'h0000;
		r.fin = fin;
		line_end = 1'b0;
		if ((ph_state == PH_STATUS || ph_state == PH_HEADERS) && cons_cnt != 11'h7ff)
			cons_cnt++;
		if (ph_state == PH_STATUS) begin
			if (c == CH_LF && cr_seen) begin
				line_end = 1'b1;
			end else begin
				if (c != CH_CR) begin
					match_status(c);
					kept_cnt++;
					if (kept_cnt >= LINE_LIMIT)
						line_end = 1'b1;
				end
				cr_seen = (c == CH_CR);
			end
			if (line_end || fin) begin
				if (smatch == SM_DIGITS || smatch == SM_DONE) begin
					r.kind = KIND_STATUS_OK;
					if (neg)
						r.code = -acc;
					else
						r.code = (acc > CODE_POS_MAX) ? CODE_POS_MAX : acc;
					ph_state = PH_HEADERS;
				end else begin
					r.kind = KIND_MALFORMED;
					ph_state = PH_IGNORE;
				end
				start_line();
			end
		end else if (ph_state == PH_HEADERS) begin
			if (c == CH_LF && cr_seen) begin
				// a blank line is just the cr lf pair
				if (cons_cnt == 11'd2) begin
					r.kind = KIND_HDR_DONE;
					ph_state = PH_PAYLOAD;
				end else begin
					r.kind = KIND_HDR_END;
				end
				start_line();
			end else if (c != CH_CR) begin
				case (fpart)
					FP_NAME: begin
						if (c == CH_COLON) begin
							fpart = FP_SKIP;
						end else begin
							r.kind = KIND_NAME;
							r.ob = c;
						end
					end
					FP_SKIP: fpart = FP_VALUE;
					default: begin
						r.kind = KIND_VALUE;
						r.ob = c;
					end
				endcase
				cr_seen = 1'b0;
				kept_cnt++;
				if (kept_cnt >= LINE_LIMIT) begin
					r.kind = KIND_HDR_END;
					start_line();
				end
			end else begin
				cr_seen = 1'b1;
			end
		end else if (ph_state == PH_PAYLOAD) begin
			r.kind = KIND_PAYLOAD;
			r.ob = c;
		end
		if (fin)
			clear_parse();
		return r;
	endfunction

	// stimulus building
	task automatic add_str(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			frame_q.push_back(s[i]);
	endtask

	task automatic add_crlf();
		frame_q.push_back(CH_CR);
		frame_q.push_back(CH_LF);
	endtask

	function automatic logic [7:0] name_char();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(33, 126));
		while (ch == CH_COLON);
		return ch;
	endfunction

	function automatic logic [7:0] value_byte();
		case ($urandom_range(15))
			0: return CH_NUL;
			1: return CH_COLON;
			2: return CH_CR;
			3: return CH_LF;
			4: return 8'($urandom_range(128, 255));
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	// move the built response into the send queue, sometimes cut short
	task automatic flush_frame(bit may_cut);
		int n;
		int i;
		raw_beat_t b;
		n = frame_q.size();
		if (may_cut && $urandom_range(5) == 0)
			n = $urandom_range(1, n);
		for (i = 0; i < n; i++) begin
			b.data = frame_q[i];
			b.fin = (i == n - 1);
			pending_bytes.push_back(b);
		end
		frame_q.delete();
	endtask

	task automatic add_payload(int max_len);
		int n;
		int i;
		n = $urandom_range(0, max_len);
		for (i = 0; i < n; i++)
			frame_q.push_back(8'($urandom_range(255)));
	endtask

	task automatic add_directed();
		// negative code that saturates, value holding a zero byte
		add_str("HTTP/1 -99999");
		add_crlf();
		add_str(":x");
		frame_q.push_back(CH_NUL);
		add_crlf();
		add_crlf();
		frame_q.push_back(8'hff);
		flush_frame(0);
		// single byte response, malformed on its final byte
		add_str("X");
		flush_frame(0);
		// zero byte closes the status text after digits
		add_str("HTTP/2 +7");
		frame_q.push_back(CH_NUL);
		flush_frame(0);
	endtask

	// lines that run into the length cut, plus a long cr run
	task automatic add_long(int mode);
		int ls;
		int name_len;
		int i;
		if (mode == 0) begin
			add_str("HTTP/1.1 404 ");
			while (frame_q.size() < LINE_LIMIT)
				frame_q.push_back(name_char());
		end else begin
			add_str("HTTP/1.1 200");
			add_crlf();
			ls = frame_q.size();
			if (mode == 1)
				name_len = LINE_LIMIT - 1;
			else if (mode == 2)
				name_len = LINE_LIMIT - 2;
			else
				name_len = $urandom_range(1, 64);
			for (i = 0; i < name_len; i++)
				frame_q.push_back(name_char());
			frame_q.push_back(CH_COLON);
			while (frame_q.size() - ls < LINE_LIMIT)
				frame_q.push_back(8'($urandom_range(32, 126)));
			add_str("ab");
			add_crlf();
			if (mode == 3) begin
				add_str("q");
				repeat (2100) frame_q.push_back(CH_CR);
				frame_q.push_back(CH_LF);
			end
		end
		add_crlf();
		add_payload(6);
		flush_frame(0);
	endtask

	task automatic add_response();
		int sel;
		int n;
		int i;
		int h;
		sel = $urandom_range(9);
		if (sel == 0) begin
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++)
				frame_q.push_back(8'($urandom_range(255)));
		end else begin
			if ($urandom_range(15) == 0)
				add_str(" ");
			add_str("HTTP/");
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++)
				frame_q.push_back(8'($urandom_range(33, 126)));
			n = $urandom_range(1, 2);
			for (i = 0; i < n; i++)
				frame_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
			case ($urandom_range(3))
				0: frame_q.push_back(CH_PLUS);
				1: frame_q.push_back(CH_MINUS);
				default: begin
				end
			endcase
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				frame_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
			if ($urandom_range(2) == 0)
				add_str(" OK");
			case ($urandom_range(7))
				0: frame_q.push_back(CH_LF);
				1: frame_q.push_back(CH_CR);
				default: begin
				end
			endcase
			add_crlf();
			if (sel == 1)
				frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
			h = $urandom_range(0, 4);
			repeat (h) begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					frame_q.push_back(name_char());
				// a few lines have no colon at all
				if ($urandom_range(7) != 0) begin
					frame_q.push_back(CH_COLON);
					frame_q.push_back($urandom_range(3) ? CH_SPACE : value_byte());
				end
				n = $urandom_range(0, 8);
				for (i = 0; i < n; i++)
					frame_q.push_back(value_byte());
				add_crlf();
			end
			add_crlf();
			add_payload(10);
		end
		flush_frame(1);
	endtask

	// sender
	always @(posedge clk) begin
		raw_beat_t b;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_beats.push_back(parse_byte(s_axis_tdata, s_axis_tlast));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					b = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= b.data;
					s_axis_tlast <= b.fin;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic note_error(string msg);
		if (mismatch_cnt < 10)
			$display("%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	always @(posedge clk) begin
		parsed_beat_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				note_error($sformatf("beat with nothing pending: kind %0d byte %02h code %0d last %0b",
					m_axis_tuser, m_axis_tdata[7:0], $signed(m_axis_tdata[23:8]),
					m_axis_tlast));
			end else begin
				e = expected_beats.pop_front();
				if (m_axis_tuser !== e.kind || m_axis_tdata[7:0] !== e.ob ||
						m_axis_tdata[23:8] !== e.code || m_axis_tlast !== e.fin)
					note_error($sformatf({"mismatch (exp/got): kind %0d/%0d byte %02h/%02h ",
						"code %0d/%0d last %0b/%0b"}, e.kind, m_axis_tuser, e.ob,
						m_axis_tdata[7:0], $signed(e.code), $signed(m_axis_tdata[23:8]),
						e.fin, m_axis_tlast));
			end
		end
	end

	initial begin
		int step;
		int base;
		clear_parse();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (step = 0; step < 4; step++) begin
			@(negedge clk);
			case (step)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct = 16;
					recv_stall_pct = 16;
				end
			endcase
			if (step == 0)
				add_directed();
			add_long(step);
			base = pending_bytes.size();
			while (pending_bytes.size() - base < 112)
				add_response();
			// wait until every beat of this stretch is back before the next stretch
			while (pending_bytes.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
				@(negedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0 && expected_beats.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
rtl/core/hrp_pkg.sv
rtl/core/hrp_status_scan.sv
rtl/core/hrp_parse_state.sv
rtl/core/http_response_header_parser.sv
tb/sv/tb_top.sv
